// ===== rtl/lctcw_pkg.sv =====
package lctcw_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int FRAC_BITS   = 20;
	localparam int SLOPE_W     = 52;
	localparam int WEIGHT_W    = 32;
	localparam int SUM_W       = 32;
	localparam int CNT_W       = 8;
	// step count of the shared unit; covers SLOPE_W + FRAC_BITS up to FRAC_BITS = 75
	localparam int STEP_W      = 7;

	localparam logic [CNT_W-1:0] READINGS_RST = 8'd10;
	localparam logic [CNT_W-1:0] DISCARD_RST  = 8'd5;

	localparam logic [2:0] REQ_WEIGH      = 3'd0;
	localparam logic [2:0] REQ_TARE       = 3'd1;
	localparam logic [2:0] REQ_CAL        = 3'd2;
	localparam logic [2:0] REQ_SET_OFFSET = 3'd3;
	localparam logic [2:0] REQ_SET_SLOPE  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_COLLECT = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;
	localparam logic [1:0] ST_SAT     = 2'd3;

	localparam logic [1:0] RUN_NONE = 2'd0;
	localparam logic [1:0] RUN_TARE = 2'd1;
	localparam logic [1:0] RUN_CAL  = 2'd2;

	localparam logic [0:0] REG_READINGS = 1'b0;
	localparam logic [0:0] REG_DISCARD  = 1'b1;

	localparam logic OP_MUL = 1'b0;
	localparam logic OP_DIV = 1'b1;

	typedef struct packed {
		logic [2:0]                req_type;
		logic [SAMPLE_BITS-1:0]    raw_code;
		logic signed [SLOPE_W-1:0] operand;
	} in_item_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic [SAMPLE_BITS-1:0]     reading;
		logic [SAMPLE_BITS-1:0]     offset_out;
		logic signed [SLOPE_W-1:0]  slope_out;
		logic                       run_done;
		logic [1:0]                 status;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic              op;
		logic [STEP_W-1:0] steps;
	} cmd_t;

endpackage

// ===== rtl/lctcw_arith.sv =====
module lctcw_arith #(
	parameter int FRAC_BITS = lctcw_pkg::FRAC_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lctcw_pkg::cmd_t                       cmd,
	input  logic [lctcw_pkg::SLOPE_W+FRAC_BITS-1:0] opa,
	input  logic [lctcw_pkg::SLOPE_W-1:0]         opb,
	output logic                                  done,
	output logic [lctcw_pkg::SLOPE_W:0]           hi,
	output logic [lctcw_pkg::SLOPE_W+FRAC_BITS-1:0] lo
);

	localparam int SB = lctcw_pkg::SAMPLE_BITS;
	localparam int SW = lctcw_pkg::SLOPE_W;
	localparam int DW = SW + FRAC_BITS;
	localparam int HW = SW + 1;

	logic [HW-1:0]                hi_q;
	logic [DW-1:0]                lo_q;
	logic [SW-1:0]                b_q;
	logic [lctcw_pkg::STEP_W-1:0] cnt_q;
	logic                         busy_q;
	logic                         div_q;
	logic                         done_q;

	logic [HW-1:0] add_a;
	logic [HW-1:0] add_b;
	logic          add_ci;
	logic [HW-1:0] sum;
	logic [SB:0]   r_sh;
	logic          r_lt;
	logic [HW-1:0] hi_add;

	// one adder serves both: hi + multiplicand, or shifted remainder - divisor
	assign r_sh = {hi_q[SB-1:0], lo_q[DW-1]};
	always_comb begin
		if (div_q) begin
			add_a  = {{(HW-SB-1){1'b0}}, r_sh};
			add_b  = ~{{(HW-SB){1'b0}}, b_q[SB-1:0]};
			add_ci = 1'b1;
		end else begin
			add_a  = hi_q;
			add_b  = {1'b0, b_q};
			add_ci = 1'b0;
		end
	end
	assign sum    = add_a + add_b + {{(HW-1){1'b0}}, add_ci};
	assign r_lt   = sum[HW-1];
	assign hi_add = lo_q[0] ? sum : hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			div_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == {{(lctcw_pkg::STEP_W-1){1'b0}}, 1'b1});
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
				div_q  <= cmd.op == lctcw_pkg::OP_DIV;
			end else if (busy_q) begin
				cnt_q <= cnt_q - {{(lctcw_pkg::STEP_W-1){1'b0}}, 1'b1};
				if (cnt_q == {{(lctcw_pkg::STEP_W-1){1'b0}}, 1'b1})
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			hi_q <= '0;
			lo_q <= opa;
			b_q  <= opb;
		end else if (busy_q) begin
			if (div_q) begin
				// restoring divide, quotient bits enter at the bottom
				hi_q <= {{(HW-SB){1'b0}}, r_lt ? r_sh[SB-1:0] : sum[SB-1:0]};
				lo_q <= {lo_q[DW-2:0], ~r_lt};
			end else begin
				// shift-add multiply, product bits shift into lo at the top
				hi_q <= {1'b0, hi_add[HW-1:1]};
				lo_q <= {hi_add[0], lo_q[DW-1:1]};
			end
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;

endmodule

// ===== rtl/load_cell_tare_calibrate_weigh_unit.sv =====
// Load-cell weighing with tare and span calibration.
// Input channel in_valid/in_stall/in_data carries one request beat: a raw
// two's-complement ADC word, a request type and a 52-bit operand. Every
// request yields exactly one result beat on out_valid/out_stall/out_data.
// Registers readings_count and discard_count are written through
// wr_en/wr_index/wr_data; write them only while idle (not enforced here).
// Path from input beat to result beat:
//   set, unused, collecting and nothing-kept samples: result in the cycle after
//   weigh: 24 shift-add steps of the shared unit
//   run-ending tare sample: 32 divide steps for the mean
//   run-ending calibrate sample: mean divide, then, unless the mean is the offset,
//     a 52 + FRAC_BITS step divide for the slope
// All multiply and divide steps go through one shared adder, so only one
// request is in flight; in_stall stays high until its result is loaded.
// A result waiting under out_stall holds; a new request is taken once it
// has been taken. Reset gives offset 0, slope 1.0, no run active, and
// readings_count 10, discard_count 5.
module load_cell_tare_calibrate_weigh_unit #(
	parameter int FRAC_BITS = lctcw_pkg::FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  lctcw_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lctcw_pkg::out_item_t out_data,
	input  logic                 wr_en,
	input  logic [0:0]           wr_index,
	input  logic [7:0]           wr_data
);

	localparam int SB = lctcw_pkg::SAMPLE_BITS;
	localparam int SW = lctcw_pkg::SLOPE_W;
	localparam int WW = lctcw_pkg::WEIGHT_W;
	localparam int UW = lctcw_pkg::SUM_W;
	localparam int CW = lctcw_pkg::CNT_W;
	localparam int DW = SW + FRAC_BITS;
	localparam int HW = SW + 1;
	localparam int PW = SW + SB;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_AVG  = 2'd2;
	localparam logic [1:0] S_CAL  = 2'd3;

	localparam logic [SW-1:0] ONE_SW    = {{(SW-1){1'b0}}, 1'b1};
	localparam logic [SW-1:0] SLOPE_ONE = ONE_SW << FRAC_BITS;
	localparam logic [DW-1:0] HALF_DW   = {{(DW-1){1'b0}}, 1'b1} << (SW - 1);
	localparam logic [WW-1:0] LIM_NEG   = {1'b1, {(WW-1){1'b0}}};
	localparam logic [WW-1:0] LIM_POS   = {1'b0, {(WW-1){1'b1}}};

	logic [1:0]              state_q, state_nx;
	logic [SB-1:0]           offset_q, offset_nx;
	logic [SW-1:0]           slope_q, slope_nx;
	logic [CW-1:0]           run_cnt_q, run_cnt_nx;
	logic [UW-1:0]           run_sum_q, run_sum_nx;
	logic [1:0]              run_kind_q, run_kind_nx;
	logic [CW-1:0]           readings_q;
	logic [CW-1:0]           discard_q;
	logic                    neg_q, neg_nx;
	logic                    tare_q, tare_nx;
	logic                    tneg_q, tneg_nx;
	logic [SW-1:0]           tmag_q, tmag_nx;
	logic [SB-1:0]           rd_q, rd_nx;
	logic                    out_valid_q;
	lctcw_pkg::out_item_t    out_q, out_nx;
	logic                    out_ld;

	lctcw_pkg::cmd_t         cmd;
	logic [DW-1:0]           ar_opa;
	logic [SW-1:0]           ar_opb;
	logic                    ar_done;
	logic [HW-1:0]           ar_hi;
	logic [DW-1:0]           ar_lo;

	logic                    accept;
	logic [SB-1:0]           rd;
	logic                    wd_neg;
	logic [SB-1:0]           wd_mag;
	logic                    s_neg;
	logic [SW-1:0]           s_mag;
	logic [SW-1:0]           op_u;
	logic                    op_neg;
	logic [SW-1:0]           op_mag;
	logic [SB-1:0]           off_set;
	logic [CW-1:0]           total;
	logic [1:0]              kind_in;
	logic                    fresh;
	logic [CW-1:0]           cnt_new;
	logic [UW-1:0]           sum_base;
	logic [UW-1:0]           sum_new;
	logic                    run_end;
	logic                    no_keep;
	logic [CW-1:0]           avg_div;

	logic [PW-1:0]           prod;
	logic [PW-1:0]           w_sh;
	logic                    w_sat;
	logic [WW-1:0]           w_lim;
	logic [WW-1:0]           w_mm;
	logic [WW-1:0]           w_val;
	logic [SB-1:0]           avg;
	logic                    c_neg;
	logic [SB-1:0]           c_mag;
	logic [DW-1:0]           q_lim;
	logic [DW-1:0]           q_sat;
	logic [SW-1:0]           slope_cal;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = (state_q != S_IDLE) | (out_valid_q & out_stall);

	// request-side operands
	assign rd     = in_data.raw_code ^ {1'b1, {(SB-1){1'b0}}};
	assign wd_neg = rd < offset_q;
	assign wd_mag = wd_neg ? offset_q - rd : rd - offset_q;
	assign s_neg  = slope_q[SW-1];
	assign s_mag  = s_neg ? ~slope_q + ONE_SW : slope_q;
	assign op_u   = in_data.operand;
	assign op_neg = op_u[SW-1];
	assign op_mag = op_neg ? ~op_u + ONE_SW : op_u;
	assign off_set = op_neg ? '0 : (|op_u[SW-1:SB] ? {SB{1'b1}} : op_u[SB-1:0]);

	// run bookkeeping; a sample of the other kind restarts the run
	assign total    = (readings_q == '0) ? {{(CW-1){1'b0}}, 1'b1} : readings_q;
	assign kind_in  = (in_data.req_type == lctcw_pkg::REQ_TARE) ?
		lctcw_pkg::RUN_TARE : lctcw_pkg::RUN_CAL;
	assign fresh    = run_kind_q != kind_in;
	assign cnt_new  = (fresh ? '0 : run_cnt_q) + {{(CW-1){1'b0}}, 1'b1};
	assign sum_base = fresh ? '0 : run_sum_q;
	assign sum_new  = (cnt_new > discard_q) ? sum_base + {{(UW-SB){1'b0}}, rd} : sum_base;
	assign run_end  = cnt_new >= total;
	assign no_keep  = total <= discard_q;
	assign avg_div  = total - discard_q;

	// weigh finish: drop fraction, saturate to 32 bits
	assign prod  = {ar_hi[SW-1:0], ar_lo[DW-1 -: SB]};
	assign w_sh  = prod >> FRAC_BITS;
	assign w_lim = neg_q ? LIM_NEG : LIM_POS;
	assign w_sat = (|w_sh[PW-1:WW]) | (w_sh[WW-1:0] > w_lim);
	assign w_mm  = w_sat ? w_lim : w_sh[WW-1:0];
	assign w_val = neg_q ? ~w_mm + {{(WW-1){1'b0}}, 1'b1} : w_mm;

	// mean and calibration divisor
	assign avg   = ar_lo[SB-1:0];
	assign c_neg = avg < offset_q;
	assign c_mag = c_neg ? offset_q - avg : avg - offset_q;

	// slope finish: clamp to the 52-bit signed range
	assign q_lim     = neg_q ? HALF_DW : HALF_DW - {{(DW-1){1'b0}}, 1'b1};
	assign q_sat     = (ar_lo > q_lim) ? q_lim : ar_lo;
	assign slope_cal = neg_q ? ~q_sat[SW-1:0] + ONE_SW : q_sat[SW-1:0];

	always_comb begin
		state_nx    = state_q;
		offset_nx   = offset_q;
		slope_nx    = slope_q;
		run_cnt_nx  = run_cnt_q;
		run_sum_nx  = run_sum_q;
		run_kind_nx = run_kind_q;
		neg_nx      = neg_q;
		tare_nx     = tare_q;
		tneg_nx     = tneg_q;
		tmag_nx     = tmag_q;
		rd_nx       = rd_q;
		cmd         = '0;
		ar_opa      = '0;
		ar_opb      = '0;
		out_ld      = 1'b0;
		out_nx.weight     = '0;
		out_nx.reading    = (state_q == S_IDLE) ? rd : rd_q;
		out_nx.offset_out = offset_q;
		out_nx.slope_out  = slope_q;
		out_nx.run_done   = 1'b0;
		out_nx.status     = lctcw_pkg::ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_nx = rd;
					case (in_data.req_type)
						lctcw_pkg::REQ_WEIGH: begin
							cmd.start = 1'b1;
							cmd.op    = lctcw_pkg::OP_MUL;
							cmd.steps = lctcw_pkg::STEP_W'(SB);
							ar_opa    = {{(DW-SB){1'b0}}, wd_mag};
							ar_opb    = s_mag;
							neg_nx    = s_neg ^ wd_neg;
							state_nx  = S_MUL;
						end
						lctcw_pkg::REQ_TARE, lctcw_pkg::REQ_CAL: begin
							if (run_end) begin
								run_cnt_nx  = '0;
								run_sum_nx  = '0;
								run_kind_nx = lctcw_pkg::RUN_NONE;
								if (no_keep) begin
									out_ld          = 1'b1;
									out_nx.run_done = 1'b1;
									out_nx.status   = lctcw_pkg::ST_BAD;
								end else begin
									cmd.start = 1'b1;
									cmd.op    = lctcw_pkg::OP_DIV;
									cmd.steps = lctcw_pkg::STEP_W'(UW);
									ar_opa    = {sum_new, {(DW-UW){1'b0}}};
									ar_opb    = {{(SW-CW){1'b0}}, avg_div};
									tare_nx   = kind_in == lctcw_pkg::RUN_TARE;
									tneg_nx   = op_neg;
									tmag_nx   = op_mag;
									state_nx  = S_AVG;
								end
							end else begin
								run_cnt_nx    = cnt_new;
								run_sum_nx    = sum_new;
								run_kind_nx   = kind_in;
								out_ld        = 1'b1;
								out_nx.status = lctcw_pkg::ST_COLLECT;
							end
						end
						lctcw_pkg::REQ_SET_OFFSET: begin
							offset_nx         = off_set;
							out_ld            = 1'b1;
							out_nx.offset_out = off_set;
						end
						lctcw_pkg::REQ_SET_SLOPE: begin
							slope_nx         = op_u;
							out_ld           = 1'b1;
							out_nx.slope_out = op_u;
						end
						default: begin
							out_ld = 1'b1;
						end
					endcase
				end
			end
			S_MUL: begin
				if (ar_done) begin
					out_ld        = 1'b1;
					out_nx.weight = w_val;
					out_nx.status = w_sat ? lctcw_pkg::ST_SAT : lctcw_pkg::ST_OK;
					state_nx      = S_IDLE;
				end
			end
			S_AVG: begin
				if (ar_done) begin
					if (tare_q) begin
						offset_nx         = avg;
						out_ld            = 1'b1;
						out_nx.run_done   = 1'b1;
						out_nx.offset_out = avg;
						state_nx          = S_IDLE;
					end else if (c_mag == '0) begin
						out_ld          = 1'b1;
						out_nx.run_done = 1'b1;
						out_nx.status   = lctcw_pkg::ST_BAD;
						state_nx        = S_IDLE;
					end else begin
						// target scaled by 2^FRAC_BITS over |mean - offset|
						cmd.start = 1'b1;
						cmd.op    = lctcw_pkg::OP_DIV;
						cmd.steps = lctcw_pkg::STEP_W'(DW);
						ar_opa    = {tmag_q, {FRAC_BITS{1'b0}}};
						ar_opb    = {{(SW-SB){1'b0}}, c_mag};
						neg_nx    = tneg_q ^ c_neg;
						state_nx  = S_CAL;
					end
				end
			end
			S_CAL: begin
				if (ar_done) begin
					slope_nx         = slope_cal;
					out_ld           = 1'b1;
					out_nx.run_done  = 1'b1;
					out_nx.slope_out = slope_cal;
					state_nx         = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	lctcw_arith #(
		.FRAC_BITS(FRAC_BITS)
	) u_arith (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.opa   (ar_opa),
		.opb   (ar_opb),
		.done  (ar_done),
		.hi    (ar_hi),
		.lo    (ar_lo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			offset_q    <= '0;
			slope_q     <= SLOPE_ONE;
			run_cnt_q   <= '0;
			run_sum_q   <= '0;
			run_kind_q  <= lctcw_pkg::RUN_NONE;
			readings_q  <= lctcw_pkg::READINGS_RST;
			discard_q   <= lctcw_pkg::DISCARD_RST;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_nx;
			offset_q   <= offset_nx;
			slope_q    <= slope_nx;
			run_cnt_q  <= run_cnt_nx;
			run_sum_q  <= run_sum_nx;
			run_kind_q <= run_kind_nx;
			if (out_ld)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (wr_en) begin
				case (wr_index)
					lctcw_pkg::REG_READINGS: readings_q <= wr_data;
					lctcw_pkg::REG_DISCARD:  discard_q  <= wr_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		neg_q  <= neg_nx;
		tare_q <= tare_nx;
		tneg_q <= tneg_nx;
		tmag_q <= tmag_nx;
		rd_q   <= rd_nx;
		if (out_ld)
			out_q <= out_nx;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef ASSERT_OFF
	// a result never waits while a request is being worked on
	a_busy_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q)
		else $error("result pending during computation");

	// the shared unit only finishes for a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ar_done |-> state_q != S_IDLE)
		else $error("arith done while idle");

	// no run active means empty counters
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		run_kind_q == lctcw_pkg::RUN_NONE |-> run_cnt_q == '0 && run_sum_q == '0)
		else $error("run state left over");

	// an accepted request always leaves idle or loads a result
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q || state_q != S_IDLE)
		else $error("request dropped");
`endif

endmodule

// ===== dv/tb_load_cell_tare_calibrate_weigh_unit.sv =====
`timescale 1ns / 100ps

module tb_load_cell_tare_calibrate_weigh_unit;
	import lctcw_pkg::*;

	localparam logic [23:0] SIGN_FLIP     = 24'h80_0000;
	localparam logic [51:0] SLOPE_POS_MAX = 52'h7_FFFF_FFFF_FFFF;
	localparam logic [51:0] SLOPE_NEG_MAX = 52'h8_0000_0000_0000;
	localparam logic [51:0] SLOPE_ONE     = 52'd1 << FRAC_BITS;
	localparam logic [2:0]  REQ_UNUSED_LO = 3'd5;
	localparam logic [2:0]  REQ_UNUSED_HI = 3'd7;
	localparam int          RANDOM_ITEMS  = 800;
	localparam int          PHASE_ITEMS   = 60;
	localparam int          DRAIN_CYCLES  = 120;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_item_t out_data;
	logic      wr_en = 1'b0;
	logic [0:0] wr_index = REG_READINGS;
	logic [7:0] wr_data = '0;

	logic gaps_on = 1'b1;
	int   errors = 0;

	// scale state as the block should hold it
	logic [23:0] cur_offset = '0;
	logic [51:0] cur_slope = SLOPE_ONE;
	logic [7:0]  run_cnt = '0;
	logic [31:0] run_acc = '0;
	logic [1:0]  run_mode = RUN_NONE;
	logic [7:0]  readings_cfg = READINGS_RST;
	logic [7:0]  discard_cfg = DISCARD_RST;

	out_item_t scale_outputs[$];

	load_cell_tare_calibrate_weigh_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #5 clk = ~clk;

	initial begin
		#10_000_000;
		$display("tb_load_cell_tare_calibrate_weigh_unit failed");
		$finish;
	end

	function automatic out_item_t calc_scale_output(in_item_t it);
		out_item_t   res;
		logic [23:0] rd, dmag, avg;
		logic [51:0] opnd, mag;
		logic [79:0] wide, lim;
		logic [31:0] mean;
		logic [7:0]  total;
		logic [1:0]  kind;
		logic        neg, dneg;
		res = '0;
		rd = it.raw_code ^ SIGN_FLIP;
		opnd = it.operand;
		case (it.req_type)
			REQ_WEIGH: begin
				mag = cur_slope[51] ? -cur_slope : cur_slope;
				dneg = rd < cur_offset;
				dmag = dneg ? cur_offset - rd : rd - cur_offset;
				neg = cur_slope[51] ^ dneg;
				wide = mag * dmag;
				wide = wide >> FRAC_BITS;
				lim = neg ? 80'h8000_0000 : 80'h7FFF_FFFF;
				if (wide > lim) begin
					wide = lim;
					res.status = ST_SAT;
				end
				res.weight = neg ? -wide[31:0] : wide[31:0];
			end
			REQ_TARE, REQ_CAL: begin
				kind = (it.req_type == REQ_TARE) ? RUN_TARE : RUN_CAL;
				total = (readings_cfg == 0) ? 8'd1 : readings_cfg;
				// a sample of the other kind restarts the run
				if (run_mode != kind) begin
					run_mode = kind;
					run_cnt = '0;
					run_acc = '0;
				end
				run_cnt = run_cnt + 8'd1;
				if (run_cnt > discard_cfg)
					run_acc = run_acc + rd;
				if (run_cnt >= total) begin
					res.run_done = 1'b1;
					if (total <= discard_cfg) begin
						res.status = ST_BAD;
					end else begin
						mean = run_acc / (total - discard_cfg);
						avg = mean[23:0];
						if (kind == RUN_TARE) begin
							cur_offset = avg;
						end else begin
							dneg = avg < cur_offset;
							dmag = dneg ? cur_offset - avg : avg - cur_offset;
							neg = opnd[51] ^ dneg;
							mag = opnd[51] ? -opnd : opnd;
							if (dmag == 0) begin
								res.status = ST_BAD;
							end else begin
								wide = mag;
								wide = (wide << FRAC_BITS) / dmag;
								lim = neg ? {28'd0, SLOPE_NEG_MAX} : {28'd0, SLOPE_POS_MAX};
								if (wide > lim)
									wide = lim;
								cur_slope = neg ? -wide[51:0] : wide[51:0];
							end
						end
					end
					run_mode = RUN_NONE;
					run_cnt = '0;
					run_acc = '0;
				end else begin
					res.status = ST_COLLECT;
				end
			end
			REQ_SET_OFFSET: begin
				if (opnd[51])
					cur_offset = '0;
				else if (opnd > 52'hFF_FFFF)
					cur_offset = 24'hFF_FFFF;
				else
					cur_offset = opnd[23:0];
			end
			REQ_SET_SLOPE: cur_slope = opnd;
			default: ;
		endcase
		res.reading = rd;
		res.offset_out = cur_offset;
		res.slope_out = cur_slope;
		return res;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endfunction

	// result beats are checked and out_stall is driven here
	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (scale_outputs.size() == 0) begin
					$error("result beat with no request outstanding");
					errors++;
				end else begin
					want = scale_outputs.pop_front();
					check_field("weight", want.weight, out_data.weight);
					check_field("reading", want.reading, out_data.reading);
					check_field("offset_out", want.offset_out, out_data.offset_out);
					check_field("slope_out", want.slope_out, out_data.slope_out);
					check_field("run_done", want.run_done, out_data.run_done);
					check_field("status", want.status, out_data.status);
				end
			end
			out_stall <= gaps_on && ($urandom_range(99) < 8);
		end
	end

	function automatic logic [51:0] rand52();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[51:0];
	endfunction

	// often near the current zero so weights stay in range
	function automatic logic [23:0] pick_raw();
		logic [23:0] rd;
		case ($urandom_range(9))
			0: rd = $urandom_range(1) ? 24'h00_0000 : 24'hFF_FFFF;
			1: rd = $urandom_range(1) ? 24'h7F_FFFF : 24'h80_0000;
			2, 3, 4, 5: rd = cur_offset + $urandom_range(4095) - 2048;
			default: rd = $urandom;
		endcase
		return rd ^ SIGN_FLIP;
	endfunction

	function automatic logic [51:0] pick_q20();
		logic [51:0] v;
		case ($urandom_range(4))
			0: v = SLOPE_ONE + $urandom_range(1 << 22) - (1 << 21);
			1: v = rand52();
			2: v = rand52() >> $urandom_range(51);
			3: v = -(rand52() >> $urandom_range(51));
			default: v = '0;
		endcase
		return v;
	endfunction

	task automatic send_req(logic [2:0] req, logic [23:0] raw, logic [51:0] opnd);
		in_item_t it;
		while (gaps_on && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		it.req_type = req;
		it.raw_code = raw;
		it.operand = opnd;
		in_valid <= 1'b1;
		in_data <= it;
		scale_outputs.push_back(calc_scale_output(it));
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (scale_outputs.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// block must be idle: call wait_quiet first
	task automatic set_counts(logic [7:0] readings, logic [7:0] discard);
		wr_en <= 1'b1;
		wr_index <= REG_READINGS;
		wr_data <= readings;
		@(posedge clk);
		wr_index <= REG_DISCARD;
		wr_data <= discard;
		@(posedge clk);
		wr_en <= 1'b0;
		readings_cfg = readings;
		discard_cfg = discard;
	endtask

	task automatic send_run(logic [2:0] kind, int len, inout int sent);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(9) == 0) begin
				send_req(REQ_WEIGH, pick_raw(), rand52());
				sent++;
			end
			send_req(kind, pick_raw(), pick_q20());
			sent++;
		end
	endtask

	task automatic test_weigh_extremes();
		send_req(REQ_WEIGH, 24'h00_0000, '0);
		send_req(REQ_WEIGH, 24'h7F_FFFF, '0);
		send_req(REQ_WEIGH, 24'h80_0000, '0);
		send_req(REQ_WEIGH, 24'hFF_FFFF, rand52());
	endtask

	task automatic test_set_and_saturate();
		send_req(REQ_SET_SLOPE, $urandom, SLOPE_POS_MAX);
		send_req(REQ_WEIGH, 24'h7F_FFFF, '0);
		send_req(REQ_SET_SLOPE, $urandom, SLOPE_NEG_MAX);
		send_req(REQ_WEIGH, 24'h7F_FFFF, '0);
		// negative offset clamps to zero, huge one to full scale
		send_req(REQ_SET_OFFSET, 24'h80_0000, '1);
		send_req(REQ_SET_OFFSET, 24'h7F_FFFF, SLOPE_POS_MAX);
		send_req(REQ_WEIGH, 24'h00_0000, '0);
	endtask

	task automatic test_unused_requests();
		for (int r = REQ_UNUSED_LO; r <= REQ_UNUSED_HI; r++)
			send_req(3'(r), $urandom, rand52());
	endtask

	task automatic test_tare_and_zero_divisor();
		logic [23:0] raw;
		raw = $urandom;
		wait_quiet();
		set_counts(8'd2, 8'd1);
		send_req(REQ_TARE, raw, rand52());
		send_req(REQ_TARE, raw, rand52());
		// calibrating on the tare point leaves nothing to divide by
		send_req(REQ_CAL, raw, pick_q20());
		send_req(REQ_CAL, raw, pick_q20());
	endtask

	task automatic test_nothing_kept();
		wait_quiet();
		set_counts(8'd1, 8'd1);
		send_req(REQ_TARE, $urandom, rand52());
	endtask

	task automatic test_kind_switch_and_slope_overflow();
		logic [23:0] rd;
		wait_quiet();
		set_counts(8'd2, 8'd0);
		send_req(REQ_TARE, $urandom, '0);
		rd = (cur_offset == 24'hFF_FFFF) ? cur_offset - 24'd1 : cur_offset + 24'd1;
		send_req(REQ_CAL, rd ^ SIGN_FLIP, SLOPE_POS_MAX);
		send_req(REQ_CAL, rd ^ SIGN_FLIP, SLOPE_POS_MAX);
	endtask

	task automatic test_count_shrink();
		wait_quiet();
		set_counts(8'd4, 8'd0);
		send_req(REQ_TARE, pick_raw(), '0);
		send_req(REQ_WEIGH, pick_raw(), '0);
		wait_quiet();
		set_counts(8'd1, 8'd0);
		send_req(REQ_TARE, 24'h7F_FFFF, '0);
	endtask

	task automatic test_random_traffic();
		int          sent, phase, first, sel, len;
		logic [7:0]  rc, dc;
		logic [51:0] opnd;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase % 8)
				1: begin
					rc = 8'd255;
					dc = 8'd254;
				end
				2: begin
					rc = 8'd1;
					dc = 8'd0;
				end
				3: begin
					rc = 8'd4;
					dc = 8'd4 + $urandom_range(250);
				end
				5: begin
					rc = 8'd255;
					dc = 8'd0;
				end
				default: begin
					rc = $urandom_range(2, 12);
					dc = $urandom_range(0, rc - 1);
				end
			endcase
			wait_quiet();
			gaps_on <= (phase % 8 != 4);
			set_counts(rc, dc);
			if (rc > 12)
				send_run($urandom_range(1) ? REQ_TARE : REQ_CAL, rc, sent);
			first = sent;
			while (sent - first < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
				sel = $urandom_range(99);
				if (sel < 35) begin
					if (rc > 12)
						len = $urandom_range(1, 20);
					else
						len = ($urandom_range(4) == 0) ? $urandom_range(1, rc) : rc;
					send_run($urandom_range(1) ? REQ_TARE : REQ_CAL, len, sent);
				end else if (sel < 65) begin
					send_req(REQ_WEIGH, pick_raw(), rand52());
					sent++;
				end else if (sel < 75) begin
					case ($urandom_range(4))
						0: opnd = -(rand52() >> $urandom_range(51));
						1: opnd = rand52();
						default: opnd = $urandom_range(24'hFF_FFFF);
					endcase
					send_req(REQ_SET_OFFSET, $urandom, opnd);
					sent++;
				end else if (sel < 85) begin
					send_req(REQ_SET_SLOPE, $urandom, pick_q20());
					sent++;
				end else if (sel < 95) begin
					send_req($urandom_range(1) ? REQ_TARE : REQ_CAL, pick_raw(), pick_q20());
					sent++;
				end else begin
					send_req($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI), $urandom, rand52());
				end
			end
			phase++;
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_weigh_extremes();
		test_set_and_saturate();
		test_unused_requests();
		test_tare_and_zero_divisor();
		test_nothing_kept();
		test_kind_switch_and_slope_overflow();
		test_count_shrink();
		test_random_traffic();
		wait_quiet();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && scale_outputs.size() == 0)
			$display("tb_load_cell_tare_calibrate_weigh_unit passed");
		else
			$display("tb_load_cell_tare_calibrate_weigh_unit failed");
		$finish;
	end

endmodule
